>>> hw/rtl/sfs_pkg.sv
// Shared constants and widths for the sprite frame sequencer.
package sfs_pkg;

   localparam int MAX_ANIMATIONS = 16;
   localparam int MAX_FRAMES     = 256;

   localparam int ANIM_W  = $clog2(MAX_ANIMATIONS);
   localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
   localparam int FRAME_W = 8;
   localparam int TIME_W  = 24;
   localparam int ACC_W   = 25;
   localparam int COUNT_W = 32;
   localparam int TYPE_W  = 3;
   localparam int MODE_W  = 2;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 48;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAMES);

   localparam logic [TYPE_W-1:0] REQ_TICK     = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_RUN      = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_SET_ANIM = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_SET_FRM  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LOAD     = 3'd4;

   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP     = 2'd2;

endpackage

>>> hw/rtl/sfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/sprite_frame_sequencer.sv
// Sprite animation frame sequencer top level with frame-length table in RAM.
//
//   Channel  Direction  Payload
//   req      in         tuser: req_type; tdata: request fields
//   rsp      out        tdata: status and current animation state
//   csr      in         data: frame_delay_us
//
// A request passes through three steps: accept with table read, execute, result.
// A tick that advances a looping animation adds a bit-serial division step for
// the remainder of the next frame by the animation length.
// Synchronous reset clears all control state and the table valid bits;
// entries never loaded read as zero length.
// A stalled result holds in the output register; the next request waits.
module sprite_frame_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // req_type
   input  logic [sfs_pkg::TYPE_W-1:0]   req_tuser,
   // elapsed_us, animation_id, end_style, frame_index, flag_value, frame_count
   input  logic [sfs_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status, current_animation, current_frame_out, frames_spent,
   // animating_out, advanced, zero pad
   output logic [sfs_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sfs_pkg::TIME_W-1:0]   csr_data
);
   import sfs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int CNT_W = $clog2(LEN_W);

   logic [1:0]               state_ff, state_in;
   logic [TIME_W-1:0]        delay_ff, delay_in;
   logic [ACC_W-1:0]         accum_ff, accum_in;
   logic                     animating_ff, animating_in;
   logic                     reverse_ff, reverse_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [ANIM_W-1:0]        active_ff, active_in;
   logic                     started_ff, started_in;
   logic [FRAME_W-1:0]       frame_ff, frame_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [MAX_ANIMATIONS-1:0] valid_ff, valid_in;

   logic [TYPE_W-1:0]        type_ff, type_in;
   logic [TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic [ANIM_W-1:0]        addr_ff, addr_in;
   logic [MODE_W-1:0]        style_ff, style_in;
   logic [FRAME_W-1:0]       fidx_ff, fidx_in;
   logic                     flag_ff, flag_in;
   logic                     status_ff, status_in;
   logic                     advanced_ff, advanced_in;

   logic [LEN_W-1:0]         dvd_ff, dvd_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic [LEN_W-1:0]         dlen_ff, dlen_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                     req_xfer;
   logic                     load_wr;
   logic [ANIM_W-1:0]        req_id;
   logic [LEN_W-1:0]         req_count;
   logic [LEN_W-1:0]         load_len;
   logic [LEN_W-1:0]         rd_len;
   logic [LEN_W-1:0]         cur_len;
   logic [ACC_W:0]           acc_sum;
   logic [ACC_W-1:0]         acc_sat;
   logic [LEN_W-1:0]         rem_shift;
   logic [LEN_W-1:0]         frame_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_id    = req_tdata[27:24];
   assign req_count = req_tdata[47:39];
   assign load_len  = (req_count > LEN_MAX) ? LEN_MAX : req_count;
   assign load_wr   = req_xfer && (req_tuser == REQ_LOAD);

   sfs_ram #(
      .WIDTH(LEN_W),
      .DEPTH(MAX_ANIMATIONS)
   ) u_len_ram (
      .clock  (clock),
      .wr_en  (load_wr),
      .wr_addr(req_id),
      .wr_data(load_len),
      .rd_addr(addr_in),
      .rd_data(rd_len)
   );

   assign cur_len   = valid_ff[addr_ff] ? rd_len : '0;
   assign acc_sum   = {1'b0, accum_ff} + (ACC_W + 1)'(elapsed_ff);
   assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign rem_shift = {rem_ff[LEN_W-2:0], dvd_ff[LEN_W-1]};
   assign frame_ext = LEN_W'(frame_ff);

   always_comb begin
      state_in     = state_ff;
      delay_in     = delay_ff;
      accum_in     = accum_ff;
      animating_in = animating_ff;
      reverse_in   = reverse_ff;
      mode_in      = mode_ff;
      active_in    = active_ff;
      started_in   = started_ff;
      frame_in     = frame_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      type_in      = type_ff;
      elapsed_in   = elapsed_ff;
      addr_in      = addr_ff;
      style_in     = style_ff;
      fidx_in      = fidx_ff;
      flag_in      = flag_ff;
      status_in    = status_ff;
      advanced_in  = advanced_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dlen_in      = dlen_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         delay_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               type_in    = req_tuser;
               elapsed_in = req_tdata[23:0];
               style_in   = req_tdata[29:28];
               fidx_in    = req_tdata[37:30];
               flag_in    = req_tdata[38];
               addr_in    = (req_tuser == REQ_TICK) ? active_ff : req_id;
               if (load_wr) begin
                  valid_in[req_id] = 1'b1;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in   = 1'b0;
            advanced_in = 1'b0;
            state_in    = ST_DONE;
            case (type_ff)
               REQ_TICK: begin
                  if (started_ff) begin
                     accum_in = acc_sat;
                     if (animating_ff && (acc_sat > ACC_W'(delay_ff))) begin
                        accum_in    = '0;
                        count_in    = count_ff + 1'b1;
                        advanced_in = 1'b1;
                        if (cur_len != '0) begin
                           case (mode_ff)
                              MODE_LOOP: begin
                                 dvd_in   = frame_ext + 1'b1;
                                 rem_in   = '0;
                                 dlen_in  = cur_len;
                                 cnt_in   = CNT_W'(LEN_W - 1);
                                 state_in = ST_DIV;
                              end
                              MODE_PINGPONG: begin
                                 if (cur_len > LEN_W'(1)) begin
                                    if ((frame_ext >= cur_len - 1'b1) ||
                                        ((frame_ff == '0) && reverse_ff)) begin
                                       reverse_in = !reverse_ff;
                                    end
                                    if (reverse_in) begin
                                       frame_in = frame_ff - 1'b1;
                                    end else begin
                                       frame_in = frame_ff + 1'b1;
                                    end
                                 end
                              end
                              MODE_STOP: begin
                                 if (frame_ext < cur_len - 1'b1) begin
                                    frame_in = frame_ff + 1'b1;
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end
               end
               REQ_RUN: begin
                  if (cur_len == '0) begin
                     status_in = 1'b1;
                  end else begin
                     animating_in = 1'b1;
                     mode_in      = style_ff;
                     active_in    = addr_ff;
                     started_in   = 1'b1;
                     frame_in     = '0;
                     count_in     = '0;
                  end
               end
               REQ_SET_ANIM: begin
                  animating_in = flag_ff;
               end
               REQ_SET_FRM: begin
                  frame_in = fidx_ff;
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[LEN_W-2:0], 1'b0};
            if (rem_shift >= dlen_ff) begin
               rem_in = rem_shift - dlen_ff;
            end else begin
               rem_in = rem_shift;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               frame_in = rem_in[FRAME_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, advanced_ff, animating_ff, count_ff, frame_ff,
                               active_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= '0;
         accum_ff     <= '0;
         animating_ff <= 1'b0;
         reverse_ff   <= 1'b0;
         mode_ff      <= MODE_LOOP;
         active_ff    <= '0;
         started_ff   <= 1'b0;
         frame_ff     <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         accum_ff     <= accum_in;
         animating_ff <= animating_in;
         reverse_ff   <= reverse_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         started_ff   <= started_in;
         frame_ff     <= frame_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      elapsed_ff  <= elapsed_in;
      addr_ff     <= addr_in;
      style_ff    <= style_in;
      fidx_ff     <= fidx_in;
      flag_ff     <= flag_in;
      status_ff   <= status_in;
      advanced_ff <= advanced_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dlen_ff     <= dlen_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ((dlen_ff != '0) && (rem_ff < dlen_ff)))
      else $error("frame remainder out of range");

   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> ((accum_ff == '0) && (count_ff == '0)))
      else $error("timing state moved before any animation started");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> ((state_ff == ST_DONE) || (state_ff == ST_DIV)))
      else $error("execute step did not lead to a result");

endmodule
